// ===== hw/rtl/gbn_rx_pkg.sv =====
// shared types and constants for the go-back-n receiver
package gbn_rx_pkg;

    localparam int SEQ_W     = 15;
    localparam int SUM_W     = 17;
    localparam int TICK_W    = 16;
    localparam int RETRY_W   = 4;
    localparam int LEN_W     = 10;
    localparam int HDR_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_SEQ     = 2'd0,
        CFG_TIMEOUT_TICKS   = 2'd1,
        CFG_MAX_FIN_RETRIES = 2'd2,
        CFG_UNUSED          = 2'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        PH_LISTEN    = 4'b0001,
        PH_HANDSHAKE = 4'b0010,
        PH_DATA      = 4'b0100,
        PH_CLOSING   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [SEQ_W-1:0] send_seq;
        logic [SEQ_W-1:0] send_ack;
        logic             send_syn;
        logic             send_ack_bit;
        logic             send_fin;
        logic             accept_payload;
        logic             is_dup_ack;
        logic             is_retransmit;
        logic             conn_closed;
        logic             last;
    } t_result;

endpackage

// ===== hw/rtl/gbn_rx_mod.sv =====
// residue of a 17-bit value modulo the sequence space, by chunk tables and one fold
module gbn_rx_mod #(
    parameter int SEQ_MODULUS = 25601
) (
    input  logic [gbn_rx_pkg::SUM_W-1:0] i_value,
    output logic [gbn_rx_pkg::SEQ_W-1:0] o_residue
);

    localparam logic [gbn_rx_pkg::SUM_W-1:0] MOD1 = gbn_rx_pkg::SUM_W'(SEQ_MODULUS);
    localparam logic [gbn_rx_pkg::SUM_W-1:0] MOD2 = gbn_rx_pkg::SUM_W'(2 * SEQ_MODULUS);

    logic [gbn_rx_pkg::SEQ_W-1:0] w_lo_tbl  [64];
    logic [gbn_rx_pkg::SEQ_W-1:0] w_mid_tbl [64];
    logic [gbn_rx_pkg::SEQ_W-1:0] w_hi_tbl  [32];
    logic [gbn_rx_pkg::SUM_W-1:0] w_sum;

    // weight of each chunk reduced at elaboration
    for (genvar g = 0; g < 64; g++) begin : g_lo_mid
        assign w_lo_tbl[g]  = gbn_rx_pkg::SEQ_W'(g % SEQ_MODULUS);
        assign w_mid_tbl[g] = gbn_rx_pkg::SEQ_W'((g * 64) % SEQ_MODULUS);
    end
    for (genvar g = 0; g < 32; g++) begin : g_hi
        assign w_hi_tbl[g] = gbn_rx_pkg::SEQ_W'((g * 4096) % SEQ_MODULUS);
    end

    // three partial residues sum below three moduli
    assign w_sum = gbn_rx_pkg::SUM_W'(w_lo_tbl[i_value[5:0]])
                 + gbn_rx_pkg::SUM_W'(w_mid_tbl[i_value[11:6]])
                 + gbn_rx_pkg::SUM_W'(w_hi_tbl[i_value[16:12]]);

    always_comb begin
        priority if (w_sum >= MOD2) begin
            o_residue = gbn_rx_pkg::SEQ_W'(w_sum - MOD2);
        end else if (w_sum >= MOD1) begin
            o_residue = gbn_rx_pkg::SEQ_W'(w_sum - MOD1);
        end else begin
            o_residue = gbn_rx_pkg::SEQ_W'(w_sum);
        end
    end

endmodule

// ===== hw/rtl/go_back_n_receiver.sv =====
// go-back-n receiver: connection phases, cumulative ack and fin retransmit
//
//  channel  signals                              direction  payload
//  in       i_in_valid / o_in_ready              to block   header fields or timer tick
//  out      o_out_valid / i_out_ready            from block one outgoing header or close mark
//  cfg      i_cfg_valid / o_cfg_ready            to block   i_cfg_index, i_cfg_data
//
//  one item per cycle while two queue slots are free: an input register, the phase logic, then a 4-entry result queue
//  an item waits in the input register until the phase logic takes it and writes its results to the result queue
//  a fin in order makes two results; the phase logic waits while fewer than two queue slots are free
//  reset (synchronous, active low) empties the input register and the queue and returns to listen
//  the config port never stalls
module go_back_n_receiver #(
    parameter int SEQ_MODULUS = 25601,
    parameter int MAX_PAYLOAD = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_in_kind,
    input  logic [15:0] i_in_seq_num,
    input  logic [15:0] i_in_ack_num,
    input  logic        i_in_ack_bit,
    input  logic        i_in_fin_bit,
    input  logic [9:0]  i_in_payload_len,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_out_send_seq,
    output logic [14:0] o_out_send_ack,
    output logic        o_out_send_syn,
    output logic        o_out_send_ack_bit,
    output logic        o_out_send_fin,
    output logic        o_out_accept_payload,
    output logic        o_out_is_dup_ack,
    output logic        o_out_is_retransmit,
    output logic        o_out_conn_closed,
    output logic        o_out_last,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SEQ_W  = gbn_rx_pkg::SEQ_W;
    localparam int SUM_W  = gbn_rx_pkg::SUM_W;
    localparam int TICK_W = gbn_rx_pkg::TICK_W;
    localparam int RTR_W  = gbn_rx_pkg::RETRY_W;
    localparam int PTR_W  = gbn_rx_pkg::OUTQ_PTR_W;
    localparam int CNT_W  = gbn_rx_pkg::OUTQ_CNT_W;
    localparam int LEN_XW = 13;

    localparam logic [SUM_W-1:0]  MOD1     = SUM_W'(SEQ_MODULUS);
    localparam logic [LEN_XW-1:0] MAX_LEN  = LEN_XW'(MAX_PAYLOAD);
    localparam logic [CNT_W-1:0]  ROOM_MAX = CNT_W'(gbn_rx_pkg::OUTQ_DEPTH - 2);

    // configuration
    logic [SEQ_W-1:0]  r_iss;
    logic [TICK_W-1:0] r_timeout;
    logic [RTR_W-1:0]  r_max_retries;
    logic [SEQ_W-1:0]  w_cfg_residue;

    // input register
    logic              r_in_valid;
    logic              r_kind;
    logic [15:0]       r_seq;
    logic [15:0]       r_ackn;
    logic              r_ackf;
    logic              r_finf;
    logic [9:0]        r_len;

    // connection state
    gbn_rx_pkg::t_phase r_phase, n_phase;
    logic [SEQ_W-1:0]  r_expected, n_expected;
    logic [SEQ_W-1:0]  r_server_seq, n_server_seq;
    logic [SEQ_W-1:0]  r_synack_ack, n_synack_ack;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [RTR_W-1:0]  r_retries, n_retries;

    // result queue
    gbn_rx_pkg::t_result r_q [gbn_rx_pkg::OUTQ_DEPTH];
    logic [PTR_W-1:0]  r_head, r_tail;
    logic [CNT_W-1:0]  r_count;

    logic              w_fire;
    logic              w_pop;
    logic [1:0]        w_push;
    gbn_rx_pkg::t_result w_res0, w_res1;

    logic [LEN_XW-1:0] w_len;
    logic [SUM_W-1:0]  w_seq_inc;
    logic [SUM_W-1:0]  w_seq_len;
    logic [SEQ_W-1:0]  w_inc_mod;
    logic [SEQ_W-1:0]  w_len_mod;
    logic [SUM_W-1:0]  w_srv_inc;
    logic [SUM_W-1:0]  w_fin_ack;
    logic [TICK_W-1:0] w_tick_next;
    logic              w_timeout;

    gbn_rx_mod #(.SEQ_MODULUS(SEQ_MODULUS)) u_mod_cfg (
        .i_value   ({2'b00, i_cfg_data[SEQ_W-1:0]}),
        .o_residue (w_cfg_residue)
    );

    gbn_rx_mod #(.SEQ_MODULUS(SEQ_MODULUS)) u_mod_inc (
        .i_value   (w_seq_inc),
        .o_residue (w_inc_mod)
    );

    gbn_rx_mod #(.SEQ_MODULUS(SEQ_MODULUS)) u_mod_len (
        .i_value   (w_seq_len),
        .o_residue (w_len_mod)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss         <= '0;
            r_timeout     <= TICK_W'(500);
            r_max_retries <= RTR_W'(12);
        end else if (i_cfg_valid) begin
            unique case (gbn_rx_pkg::t_cfg_index'(i_cfg_index))
                gbn_rx_pkg::CFG_INITIAL_SEQ:     r_iss         <= w_cfg_residue;
                gbn_rx_pkg::CFG_TIMEOUT_TICKS:   r_timeout     <= i_cfg_data;
                gbn_rx_pkg::CFG_MAX_FIN_RETRIES: r_max_retries <= i_cfg_data[RTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // the phase logic needs two free queue slots
    assign w_fire     = r_in_valid && (r_count <= ROOM_MAX);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_in_kind;
            r_seq  <= i_in_seq_num;
            r_ackn <= i_in_ack_num;
            r_ackf <= i_in_ack_bit;
            r_finf <= i_in_fin_bit;
            r_len  <= i_in_payload_len;
        end
    end

    assign w_len       = ({3'b000, r_len} > MAX_LEN) ? MAX_LEN : {3'b000, r_len};
    assign w_seq_inc   = SUM_W'(r_seq) + SUM_W'(1);
    assign w_seq_len   = SUM_W'(r_seq) + SUM_W'(w_len);
    assign w_srv_inc   = SUM_W'(r_server_seq) + SUM_W'(1);
    assign w_fin_ack   = (w_srv_inc >= MOD1) ? (w_srv_inc - MOD1) : w_srv_inc;
    assign w_tick_next = r_ticks + TICK_W'(1);
    assign w_timeout   = (w_tick_next >= r_timeout);

    always_comb begin
        n_phase      = r_phase;
        n_expected   = r_expected;
        n_server_seq = r_server_seq;
        n_synack_ack = r_synack_ack;
        n_ticks      = r_ticks;
        n_retries    = r_retries;
        w_res0       = '0;
        w_res1       = '0;
        w_push       = 2'd0;
        w_res0.last  = 1'b1;
        if (w_fire) begin
            unique case (r_phase)
                gbn_rx_pkg::PH_LISTEN: begin
                    if (!r_kind) begin
                        n_server_seq = r_iss + SEQ_W'(1);
                        n_synack_ack = w_inc_mod;
                        n_ticks      = '0;
                        n_phase      = gbn_rx_pkg::PH_HANDSHAKE;
                        w_res0.send_seq     = r_iss;
                        w_res0.send_ack     = w_inc_mod;
                        w_res0.send_syn     = 1'b1;
                        w_res0.send_ack_bit = 1'b1;
                        w_push = 2'd1;
                    end
                end
                gbn_rx_pkg::PH_HANDSHAKE: begin
                    if (r_kind) begin
                        n_ticks = w_tick_next;
                        if (w_timeout) begin
                            n_ticks = '0;
                            w_res0.send_seq      = r_server_seq - SEQ_W'(1);
                            w_res0.send_ack      = r_synack_ack;
                            w_res0.send_syn      = 1'b1;
                            w_res0.send_ack_bit  = 1'b1;
                            w_res0.is_retransmit = 1'b1;
                            w_push = 2'd1;
                        end
                    end else if (r_ackf) begin
                        n_expected = w_len_mod;
                        n_phase    = gbn_rx_pkg::PH_DATA;
                        w_res0.send_seq       = r_server_seq;
                        w_res0.send_ack       = w_len_mod;
                        w_res0.send_ack_bit   = 1'b1;
                        w_res0.accept_payload = 1'b1;
                        w_push = 2'd1;
                    end
                end
                gbn_rx_pkg::PH_DATA: begin
                    if (!r_kind) begin
                        w_res0.send_seq     = r_server_seq;
                        w_res0.send_ack_bit = 1'b1;
                        w_push = 2'd1;
                        if (r_seq != {1'b0, r_expected}) begin
                            w_res0.send_ack   = r_expected;
                            w_res0.is_dup_ack = 1'b1;
                        end else if (r_finf) begin
                            // fin-ack, then our own fin
                            w_res0.send_ack  = w_inc_mod;
                            w_res0.last      = 1'b0;
                            w_res1.send_seq  = r_server_seq;
                            w_res1.send_fin  = 1'b1;
                            w_res1.last      = 1'b1;
                            w_push     = 2'd2;
                            n_expected = w_inc_mod;
                            n_phase    = gbn_rx_pkg::PH_CLOSING;
                            n_ticks    = '0;
                            n_retries  = '0;
                        end else begin
                            w_res0.send_ack       = w_len_mod;
                            w_res0.accept_payload = 1'b1;
                            n_expected = w_len_mod;
                        end
                    end
                end
                gbn_rx_pkg::PH_CLOSING: begin
                    if (r_kind) begin
                        n_ticks = w_tick_next;
                        if (w_timeout) begin
                            w_push = 2'd1;
                            if (r_retries == r_max_retries) begin
                                n_phase = gbn_rx_pkg::PH_LISTEN;
                                w_res0.conn_closed = 1'b1;
                            end else begin
                                n_ticks   = '0;
                                n_retries = r_retries + RTR_W'(1);
                                w_res0.send_seq      = r_server_seq;
                                w_res0.send_fin      = 1'b1;
                                w_res0.is_retransmit = 1'b1;
                            end
                        end
                    end else if (r_ackf && (SUM_W'(r_ackn) == w_fin_ack)) begin
                        n_phase = gbn_rx_pkg::PH_LISTEN;
                        w_res0.conn_closed = 1'b1;
                        w_push = 2'd1;
                    end
                end
                default: begin
                    n_phase = gbn_rx_pkg::PH_LISTEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= gbn_rx_pkg::PH_LISTEN;
            r_expected   <= '0;
            r_server_seq <= '0;
            r_synack_ack <= '0;
            r_ticks      <= '0;
            r_retries    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_expected   <= n_expected;
            r_server_seq <= n_server_seq;
            r_synack_ack <= n_synack_ack;
            r_ticks      <= n_ticks;
            r_retries    <= n_retries;
        end
    end

    // result queue
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= r_head + PTR_W'(w_pop);
            r_tail  <= r_tail + PTR_W'(w_push);
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_q[r_tail] <= w_res0;
        end
        if (w_push == 2'd2) begin
            r_q[r_tail + PTR_W'(1)] <= w_res1;
        end
    end

    assign o_out_send_seq       = r_q[r_head].send_seq;
    assign o_out_send_ack       = r_q[r_head].send_ack;
    assign o_out_send_syn       = r_q[r_head].send_syn;
    assign o_out_send_ack_bit   = r_q[r_head].send_ack_bit;
    assign o_out_send_fin       = r_q[r_head].send_fin;
    assign o_out_accept_payload = r_q[r_head].accept_payload;
    assign o_out_is_dup_ack     = r_q[r_head].is_dup_ack;
    assign o_out_is_retransmit  = r_q[r_head].is_retransmit;
    assign o_out_conn_closed    = r_q[r_head].conn_closed;
    assign o_out_last           = r_q[r_head].last;

endmodule

// ===== hw/rtl/gbn_rx_chk.sv =====
// port-level checks for the go-back-n receiver, bound to the top level
module gbn_rx_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [14:0] o_out_send_seq,
    input logic [14:0] o_out_send_ack,
    input logic        o_out_send_syn,
    input logic        o_out_send_ack_bit,
    input logic        o_out_send_fin,
    input logic        o_out_conn_closed,
    input logic        o_out_last
);

    // queue and input register empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("item pending right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_send_seq)
                                           && $stable(o_out_last)))
        else $error("stalled result changed");

    // a fin-ack is always followed at once by the server fin
    a_fin_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_last) |=>
            (o_out_valid && o_out_send_fin && o_out_last && !o_out_send_ack_bit))
        else $error("fin-ack not followed by server fin");

    a_closed_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_conn_closed) |->
            (o_out_send_seq == 15'd0 && o_out_send_ack == 15'd0 && !o_out_send_syn
             && !o_out_send_ack_bit && !o_out_send_fin && o_out_last))
        else $error("close mark carries a header");

    a_syn_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_send_syn) |-> (o_out_send_ack_bit && !o_out_send_fin
                                             && o_out_last))
        else $error("syn without ack flag");

endmodule

bind go_back_n_receiver gbn_rx_chk u_gbn_rx_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_out_send_seq      (o_out_send_seq),
    .o_out_send_ack      (o_out_send_ack),
    .o_out_send_syn      (o_out_send_syn),
    .o_out_send_ack_bit  (o_out_send_ack_bit),
    .o_out_send_fin      (o_out_send_fin),
    .o_out_conn_closed   (o_out_conn_closed),
    .o_out_last          (o_out_last)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the go-back-n receiver: directed connections, then random traffic
module testbench;

    localparam int SEQ_MOD           = 25601;
    localparam int PAYLOAD_MAX       = 512;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int DRAIN_CYCLES      = 6;
    localparam int RANDOM_PER_MODE   = 460;
    localparam int ITEMS_PER_SETTING = 46;

    typedef struct packed {
        logic        tick;
        logic [15:0] seq;
        logic [15:0] ack;
        logic        ack_bit;
        logic        fin_bit;
        logic [9:0]  len;
    } t_rx_item;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        in_kind = 1'b0;
    logic [15:0] in_seq_num = '0;
    logic [15:0] in_ack_num = '0;
    logic        in_ack_bit = 1'b0;
    logic        in_fin_bit = 1'b0;
    logic [9:0]  in_payload_len = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [14:0] out_send_seq;
    logic [14:0] out_send_ack;
    logic        out_send_syn;
    logic        out_send_ack_bit;
    logic        out_send_fin;
    logic        out_accept_payload;
    logic        out_is_dup_ack;
    logic        out_is_retransmit;
    logic        out_conn_closed;
    logic        out_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // connection state and settings as the block should hold them
    gbn_rx_pkg::t_phase             ph = gbn_rx_pkg::PH_LISTEN;
    logic [gbn_rx_pkg::SEQ_W-1:0]   rx_next_seq = '0;
    logic [gbn_rx_pkg::SEQ_W-1:0]   tx_seq = '0;
    logic [gbn_rx_pkg::SEQ_W-1:0]   synack_ackno = '0;
    logic [gbn_rx_pkg::TICK_W-1:0]  ticks_elapsed = '0;
    logic [gbn_rx_pkg::RETRY_W-1:0] fin_resends = '0;
    logic [gbn_rx_pkg::SEQ_W-1:0]   set_initial_seq = '0;
    logic [gbn_rx_pkg::TICK_W-1:0]  set_timeout = 16'd500;
    logic [gbn_rx_pkg::RETRY_W-1:0] set_max_resends = 4'd12;
    gbn_rx_pkg::t_result            replies_due[$];

    int error_count = 0;
    int cycle_count = 0;
    int sent_items = 0;
    int tx_idle_pct = 29;
    int rx_idle_pct = 63;

    go_back_n_receiver uut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_in_kind            (in_kind),
        .i_in_seq_num         (in_seq_num),
        .i_in_ack_num         (in_ack_num),
        .i_in_ack_bit         (in_ack_bit),
        .i_in_fin_bit         (in_fin_bit),
        .i_in_payload_len     (in_payload_len),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_out_send_seq       (out_send_seq),
        .o_out_send_ack       (out_send_ack),
        .o_out_send_syn       (out_send_syn),
        .o_out_send_ack_bit   (out_send_ack_bit),
        .o_out_send_fin       (out_send_fin),
        .o_out_accept_payload (out_accept_payload),
        .o_out_is_dup_ack     (out_is_dup_ack),
        .o_out_is_retransmit  (out_is_retransmit),
        .o_out_conn_closed    (out_conn_closed),
        .o_out_last           (out_last),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic gbn_rx_pkg::t_result make_reply(int unsigned seqv, int unsigned ackv,
                                                       logic syn, logic ackf, logic fin,
                                                       logic acc, logic dup, logic rtx,
                                                       logic closed, logic lst);
        gbn_rx_pkg::t_result r;
        r.send_seq       = gbn_rx_pkg::SEQ_W'(seqv);
        r.send_ack       = gbn_rx_pkg::SEQ_W'(ackv);
        r.send_syn       = syn;
        r.send_ack_bit   = ackf;
        r.send_fin       = fin;
        r.accept_payload = acc;
        r.is_dup_ack     = dup;
        r.is_retransmit  = rtx;
        r.conn_closed    = closed;
        r.last           = lst;
        return r;
    endfunction

    function automatic bit timer_expired();
        ticks_elapsed = ticks_elapsed + 16'd1;
        return ticks_elapsed >= set_timeout;
    endfunction

    // advances the connection state by one item, queues the headers it sends back
    function automatic int predict_replies(t_rx_item it);
        int unsigned seqv;
        int unsigned ackv;
        int unsigned len;
        int unsigned iss;
        seqv = 32'(it.seq);
        ackv = 32'(it.ack);
        len = (32'(it.len) > PAYLOAD_MAX) ? 32'(PAYLOAD_MAX) : 32'(it.len);
        case (ph)
            gbn_rx_pkg::PH_LISTEN: begin
                if (it.tick) return 0;
                iss = 32'(set_initial_seq) % SEQ_MOD;
                tx_seq = gbn_rx_pkg::SEQ_W'(iss + 1);
                synack_ackno = gbn_rx_pkg::SEQ_W'((seqv + 1) % SEQ_MOD);
                ticks_elapsed = '0;
                ph = gbn_rx_pkg::PH_HANDSHAKE;
                replies_due.push_back(make_reply(iss, 32'(synack_ackno), 1'b1, 1'b1, 1'b0,
                                                 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
                return 1;
            end
            gbn_rx_pkg::PH_HANDSHAKE: begin
                if (it.tick) begin
                    if (!timer_expired()) return 0;
                    ticks_elapsed = '0;
                    replies_due.push_back(make_reply(32'(tx_seq) - 32'd1, 32'(synack_ackno),
                                                     1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                                     1'b0, 1'b1));
                    return 1;
                end
                if (!it.ack_bit) return 0;
                // a fin riding on the handshake ack is dropped
                rx_next_seq = gbn_rx_pkg::SEQ_W'((seqv + len) % SEQ_MOD);
                ph = gbn_rx_pkg::PH_DATA;
                replies_due.push_back(make_reply(32'(tx_seq), 32'(rx_next_seq), 1'b0, 1'b1,
                                                 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
                return 1;
            end
            gbn_rx_pkg::PH_DATA: begin
                if (it.tick) return 0;
                if (seqv != 32'(rx_next_seq)) begin
                    replies_due.push_back(make_reply(32'(tx_seq), 32'(rx_next_seq),
                                                     1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                                                     1'b0, 1'b1));
                    return 1;
                end
                if (it.fin_bit) begin
                    replies_due.push_back(make_reply(32'(tx_seq), (seqv + 1) % SEQ_MOD,
                                                     1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                                     1'b0, 1'b0));
                    rx_next_seq = gbn_rx_pkg::SEQ_W'((32'(rx_next_seq) + 1) % SEQ_MOD);
                    replies_due.push_back(make_reply(32'(tx_seq), 0, 1'b0, 1'b0, 1'b1,
                                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
                    ph = gbn_rx_pkg::PH_CLOSING;
                    ticks_elapsed = '0;
                    fin_resends = '0;
                    return 2;
                end
                rx_next_seq = gbn_rx_pkg::SEQ_W'((32'(rx_next_seq) + len) % SEQ_MOD);
                replies_due.push_back(make_reply(32'(tx_seq), 32'(rx_next_seq), 1'b0, 1'b1,
                                                 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
                return 1;
            end
            default: begin
                if (it.tick) begin
                    if (!timer_expired()) return 0;
                    if (fin_resends == set_max_resends) begin
                        ph = gbn_rx_pkg::PH_LISTEN;
                        replies_due.push_back(make_reply(0, 0, 1'b0, 1'b0, 1'b0, 1'b0,
                                                         1'b0, 1'b0, 1'b1, 1'b1));
                        return 1;
                    end
                    ticks_elapsed = '0;
                    fin_resends = fin_resends + 4'd1;
                    replies_due.push_back(make_reply(32'(tx_seq), 0, 1'b0, 1'b0, 1'b1,
                                                     1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
                    return 1;
                end
                if (it.ack_bit && ackv == (32'(tx_seq) + 1) % SEQ_MOD) begin
                    ph = gbn_rx_pkg::PH_LISTEN;
                    replies_due.push_back(make_reply(0, 0, 1'b0, 1'b0, 1'b0, 1'b0,
                                                     1'b0, 1'b0, 1'b1, 1'b1));
                    return 1;
                end
                return 0;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // results are sampled mid-cycle, the handshake completes at the next rising edge
    always @(negedge clk) begin
        gbn_rx_pkg::t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (replies_due.size() == 0) begin
                $error("unexpected result: send_seq %0d send_ack %0d closed %0b",
                       out_send_seq, out_send_ack, out_conn_closed);
                error_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("send_seq", 16'(want.send_seq), 16'(out_send_seq));
                check_field("send_ack", 16'(want.send_ack), 16'(out_send_ack));
                check_field("send_syn", 16'(want.send_syn), 16'(out_send_syn));
                check_field("send_ack_bit", 16'(want.send_ack_bit), 16'(out_send_ack_bit));
                check_field("send_fin", 16'(want.send_fin), 16'(out_send_fin));
                check_field("accept_payload", 16'(want.accept_payload),
                            16'(out_accept_payload));
                check_field("is_dup_ack", 16'(want.is_dup_ack), 16'(out_is_dup_ack));
                check_field("is_retransmit", 16'(want.is_retransmit),
                            16'(out_is_retransmit));
                check_field("conn_closed", 16'(want.conn_closed), 16'(out_conn_closed));
                check_field("last", 16'(want.last), 16'(out_last));
            end
        end
    end

    function automatic logic [9:0] rand_len();
        return ($urandom_range(99) < 15) ? 10'($urandom_range(513, 1023))
                                         : 10'($urandom_range(0, PAYLOAD_MAX));
    endfunction

    function automatic t_rx_item hdr(logic [15:0] seq, logic [15:0] ack, logic ackf,
                                     logic finf, logic [9:0] len);
        t_rx_item it;
        it.tick    = 1'b0;
        it.seq     = seq;
        it.ack     = ack;
        it.ack_bit = ackf;
        it.fin_bit = finf;
        it.len     = len;
        return it;
    endfunction

    function automatic t_rx_item tick_item();
        t_rx_item it;
        it = hdr(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), rand_len());
        it.tick = 1'b1;
        return it;
    endfunction

    // mostly well-formed traffic for whatever phase the connection is in
    function automatic t_rx_item next_random_item();
        t_rx_item    it;
        int unsigned roll;
        it = hdr(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), rand_len());
        roll = $urandom_range(99);
        case (ph)
            gbn_rx_pkg::PH_LISTEN: it.tick = (roll < 15);
            gbn_rx_pkg::PH_HANDSHAKE: begin
                it.tick = (roll < 20);
                it.ack_bit = (roll >= 35);
            end
            gbn_rx_pkg::PH_DATA: begin
                it.tick = (roll < 8);
                if (roll >= 20) begin
                    it.seq = 16'(rx_next_seq);
                    it.fin_bit = (roll < 28);
                end
            end
            default: begin
                it.tick = (roll < 45);
                if (roll >= 80) begin
                    it.ack = 16'((32'(tx_seq) + 1) % SEQ_MOD);
                    it.ack_bit = (roll >= 88);
                end
            end
        endcase
        return it;
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_item(t_rx_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_kind        <= it.tick;
        in_seq_num     <= it.seq;
        in_ack_num     <= it.ack;
        in_ack_bit     <= it.ack_bit;
        in_fin_bit     <= it.fin_bit;
        in_payload_len <= it.len;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        void'(predict_replies(it));
        sent_items++;
        @(posedge clk);
    endtask

    task automatic wait_for_replies();
        in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(gbn_rx_pkg::t_cfg_index idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        case (idx)
            gbn_rx_pkg::CFG_INITIAL_SEQ:     set_initial_seq = data[gbn_rx_pkg::SEQ_W-1:0];
            gbn_rx_pkg::CFG_TIMEOUT_TICKS:   set_timeout = data;
            gbn_rx_pkg::CFG_MAX_FIN_RETRIES: set_max_resends = data[gbn_rx_pkg::RETRY_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // settings change only once the block has gone quiet
    task automatic write_settings(logic [15:0] iseq, logic [15:0] tmo, logic [15:0] resends);
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_register(gbn_rx_pkg::CFG_INITIAL_SEQ, iseq);
        write_register(gbn_rx_pkg::CFG_TIMEOUT_TICKS, tmo);
        write_register(gbn_rx_pkg::CFG_MAX_FIN_RETRIES, resends);
        write_register(gbn_rx_pkg::CFG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_listen();
        write_settings(16'd25600, 16'd0, 16'd15);
        send_item(tick_item());
        send_item(hdr(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 10'h3FF));
    endtask

    task automatic test_handshake();
        // zero timeout: every tick resends the syn-ack
        send_item(tick_item());
        send_item(hdr(16'h0000, 16'h0000, 1'b0, 1'b0, 10'd0));
        send_item(hdr(16'd25600, 16'h0000, 1'b1, 1'b1, 10'd1023));
    endtask

    task automatic test_data_path();
        send_item(hdr(16'(rx_next_seq), 16'hFFFF, 1'b1, 1'b0, 10'd0));
        send_item(hdr(16'(rx_next_seq), 16'h0000, 1'b0, 1'b0, 10'd512));
        send_item(hdr(16'(rx_next_seq + 1), 16'h5555, 1'b1, 1'b0, 10'd100));
        send_item(tick_item());
        send_item(hdr(16'(rx_next_seq), 16'hAAAA, 1'b1, 1'b0, 10'd1000));
        send_item(hdr(16'(rx_next_seq), 16'h0000, 1'b0, 1'b1, 10'd7));
    endtask

    task automatic test_close_on_ack();
        send_item(tick_item());
        send_item(hdr(16'h1234, 16'((32'(tx_seq) + 2) % SEQ_MOD), 1'b1, 1'b0, 10'd0));
        send_item(hdr(16'h1234, 16'((32'(tx_seq) + 1) % SEQ_MOD), 1'b0, 1'b0, 10'd0));
        // server seq sits at the modulus here, so the fin is acked with 1
        send_item(hdr(16'hFFFF, 16'((32'(tx_seq) + 1) % SEQ_MOD), 1'b1, 1'b1, 10'd0));
    endtask

    task automatic test_close_on_retries();
        // initial seq above the modulus wraps
        write_settings(16'hFFFF, 16'd2, 16'd0);
        send_item(hdr(16'h8000, 16'h7FFF, 1'b0, 1'b0, 10'd0));
        send_item(hdr(16'd100, 16'h0000, 1'b1, 1'b0, 10'd512));
        send_item(hdr(16'(rx_next_seq), 16'hFFFF, 1'b1, 1'b1, 10'd0));
        send_item(tick_item());
        send_item(tick_item());
    endtask

    task automatic test_long_timeout();
        write_settings(16'd0, 16'hFFFF, 16'd15);
        send_item(hdr(16'h1234, 16'h0000, 1'b0, 1'b0, 10'd3));
        send_item(tick_item());
    endtask

    task automatic test_random_traffic();
        int          mode;
        int          stop_at;
        logic [15:0] tmo;
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 63;
                end
                1: begin
                    tx_idle_pct = 63;
                    rx_idle_pct = 29;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            sent_items = 0;
            while (sent_items < RANDOM_PER_MODE) begin
                // short timeouts mostly, so resends and give-ups come up often
                tmo = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
                write_settings(16'($urandom), tmo, 16'($urandom));
                stop_at = sent_items + ITEMS_PER_SETTING;
                while (sent_items < stop_at) send_item(next_random_item());
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_listen();
        test_handshake();
        test_data_path();
        test_close_on_ack();
        test_close_on_retries();
        test_long_timeout();
        test_random_traffic();
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
